// ----- rtl/sds_pkg.sv -----
// Shared types and codes for the two-ended stack block.
// No dependencies; imported by sds_ctrl, the top, the checker and the testbench.
package sds_pkg;

   // Operation codes carried in the request beat
   localparam logic [2:0] OP_PUSH_ONE = 3'd0;
   localparam logic [2:0] OP_PUSH_TWO = 3'd1;
   localparam logic [2:0] OP_POP_ONE  = 3'd2;
   localparam logic [2:0] OP_POP_TWO  = 3'd3;
   localparam logic [2:0] OP_PEEK_ONE = 3'd4;
   localparam logic [2:0] OP_PEEK_TWO = 3'd5;

   // Status codes carried in the response beat
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic               first_empty;
      logic               second_empty;
   } rsp_type;

   // Per-beat result of the pointer logic, minus the memory read data
   typedef struct packed {
      logic [1:0] status;
      logic       is_read;
      logic       first_empty;
      logic       second_empty;
   } step_info_type;

endpackage

// ----- rtl/sds_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module sds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one entry per cycle; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sds_ctrl.sv -----
// Stack counters and address generation for the shared store.
// Depends on sds_pkg for operation, status and step info types.
module sds_ctrl #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [2:0]                     operation,
   output logic                           mem_wr_en,
   output logic                           mem_rd_en,
   output logic [$clog2(STORE_DEPTH)-1:0] mem_addr,
   output sds_pkg::step_info_type         info
);
   import sds_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic [CW:0]   total;
   logic          full;
   logic [CW-1:0] addr_wide;
   logic          do_wr, do_rd;
   logic [1:0]    status;

   assign total = {1'b0, first_count_ff} + {1'b0, second_count_ff};
   assign full  = (total >= (CW+1)'(STORE_DEPTH));

   // Decode the operation against the current counts
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      addr_wide       = '0;
      do_wr           = 1'b0;
      do_rd           = 1'b0;
      status          = ST_OK;
      case (operation)
         OP_PUSH_ONE: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               addr_wide      = first_count_ff;
               do_wr          = 1'b1;
               first_count_in = first_count_ff + 1'b1;
            end
         end
         OP_PUSH_TWO: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               addr_wide       = CW'(STORE_DEPTH) - second_count_ff - 1'b1;
               do_wr           = 1'b1;
               second_count_in = second_count_ff + 1'b1;
            end
         end
         OP_POP_ONE, OP_PEEK_ONE: begin
            if (first_count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               addr_wide = first_count_ff - 1'b1;
               do_rd     = 1'b1;
               if (operation == OP_POP_ONE) begin
                  first_count_in = first_count_ff - 1'b1;
               end
            end
         end
         OP_POP_TWO, OP_PEEK_TWO: begin
            if (second_count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               addr_wide = CW'(STORE_DEPTH) - second_count_ff;
               do_rd     = 1'b1;
               if (operation == OP_POP_TWO) begin
                  second_count_in = second_count_ff - 1'b1;
               end
            end
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
   end

   // Advance the counters on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
      end else if (accept) begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
      end
   end

   assign mem_wr_en         = accept && do_wr;
   assign mem_rd_en         = accept && do_rd;
   assign mem_addr          = addr_wide[AW-1:0];
   assign info.status       = status;
   assign info.is_read      = do_rd;
   assign info.first_empty  = (first_count_in == '0);
   assign info.second_empty = (second_count_in == '0);

endmodule

// ----- rtl/shared_dual_stack.sv -----
// Two stacks sharing one store, growing from opposite ends.
// Accepted beats wait in stage one for RAM read data, then in the output register.
// Throughput: one beat per cycle unless the response side stalls; each beat makes
// one access to the single RAM port, and counters update at accept (no forwarding needed).
// Reset: synchronous; clears both stack counts and all valid flags, the
// store itself is not cleared (no clearing pass, ready right after reset).
module shared_dual_stack #(
   parameter int STORE_DEPTH   = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sds_pkg::rsp_type rsp_data
);
   import sds_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   logic                     accept;
   logic                     mem_wr_en, mem_rd_en;
   logic [AW-1:0]            mem_addr;
   logic [ELEMENT_WIDTH-1:0] mem_wr_data, mem_rd_data;
   logic signed [63:0]       push_ext, read_ext;
   step_info_type            info;

   logic          s1_valid_ff, s1_valid_in;
   step_info_type s1_info_ff;
   logic          s1_move;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   assign accept = req_valid && req_ready;

   sds_ctrl #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_data.operation),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .info      (info)
   );

   // Keep the low element bits of the sign-extended push value
   assign push_ext    = 64'(req_data.push_value);
   assign mem_wr_data = push_ext[ELEMENT_WIDTH-1:0];

   sds_ram #(
      .WIDTH(ELEMENT_WIDTH),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // Stage one waits for read data; it drains into the output register
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // Sign-extend the stored element and build the response beat
   assign read_ext = 64'(signed'(mem_rd_data));

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = s1_info_ff.status;
         rsp_data_in.read_value   = s1_info_ff.is_read ? read_ext[31:0] : '0;
         rsp_data_in.first_empty  = s1_info_ff.first_empty;
         rsp_data_in.second_empty = s1_info_ff.second_empty;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/sds_checker.sv -----
// Port-level checks for shared_dual_stack, attached by the bind below.
// Depends on sds_pkg for status codes and beat types.
module sds_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sds_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sds_pkg::rsp_type rsp_data
);
   import sds_pkg::*;

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed while stalled");

   // No response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Refused requests read back zero
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_value == '0)
      else $error("refused request returned data");

   // A full store cannot have both stacks empty
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL
         |-> !(rsp_data.first_empty && rsp_data.second_empty))
      else $error("full status with both stacks empty");

   // Only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == ST_OK || rsp_data.status == ST_FULL
         || rsp_data.status == ST_EMPTY)
      else $error("undefined status code");

endmodule

bind shared_dual_stack sds_checker u_sds_checker (.*);

// ----- verif/tb_shared_dual_stack.sv -----
// Testbench for shared_dual_stack: a directed table of beats, then biased random
// beats; each response is scored against its table row or an in-bench stack model.
// Depends on sds_pkg (beat types, operation and status codes) and the RTL top.
module tb_shared_dual_stack;
   timeunit 1ns;
   timeprecision 1ps;

   import sds_pkg::*;

   localparam int STORE_DEPTH    = 16;
   localparam int RANDOM_BEATS   = 1200;
   localparam int STEADY_FIRST   = 500;
   localparam int STEADY_LAST    = 700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REPORT_LIMIT   = 10;
   localparam int IDLE_PERCENT   = 30;

   // Codes outside the operation set; the block must leave state alone
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Model of the shared store and both stack depths
   logic [31:0] store_image [STORE_DEPTH];
   int          depth_one;
   int          depth_two;

   rsp_type      pending_rsp [$];
   stim_row_type plan [$];
   int           mismatches;
   bit           steady;

   shared_dual_stack dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one operation to the model and return the response it must give
   function automatic rsp_type predict_stack(input req_type b);
      rsp_type r;
      logic    full;
      r = '0;
      r.status = ST_OK;
      full = (depth_one + depth_two) >= STORE_DEPTH;
      case (b.operation)
         OP_PUSH_ONE, OP_PUSH_TWO: begin
            if (full) begin
               r.status = ST_FULL;
            end else if (b.operation == OP_PUSH_ONE) begin
               store_image[depth_one] = b.push_value;
               depth_one++;
            end else begin
               depth_two++;
               store_image[STORE_DEPTH - depth_two] = b.push_value;
            end
         end
         OP_POP_ONE, OP_PEEK_ONE: begin
            if (depth_one == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_value = store_image[depth_one - 1];
               if (b.operation == OP_POP_ONE) depth_one--;
            end
         end
         OP_POP_TWO, OP_PEEK_TWO: begin
            if (depth_two == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_value = store_image[STORE_DEPTH - depth_two];
               if (b.operation == OP_POP_TWO) depth_two--;
            end
         end
         default: ;
      endcase
      r.first_empty  = (depth_one == 0);
      r.second_empty = (depth_two == 0);
      return r;
   endfunction

   task automatic add_row(input logic [2:0] op, input logic [31:0] value, input bit typed,
                          input logic [1:0] status, input logic [31:0] rd,
                          input logic fe, input logic se);
      stim_row_type row;
      row.beat.operation     = op;
      row.beat.push_value    = value;
      row.typed              = typed;
      row.want.status        = status;
      row.want.read_value    = rd;
      row.want.first_empty   = fe;
      row.want.second_empty  = se;
      plan.push_back(row);
   endtask

   // Present one request beat, queue its response, hold until accepted
   task automatic send_beat(input req_type b, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predicted = predict_stack(b);
      pending_rsp.push_back(typed ? want : predicted);
      req_valid <= 1'b1;
      req_data  <= b;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Response side stalls at random, except in the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Score response beats and watch for a stalled handshake
   initial begin : rsp_watch
      int      quiet_cycles;
      bit      rsp_fire;
      rsp_type got;
      rsp_type exp;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         rsp_fire = rsp_valid && rsp_ready && !reset;
         got = rsp_data;
         if (rsp_fire || (req_valid && req_ready && !reset)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_fire) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected response beat: status %0d read %h empty %b%b",
                           got.status, got.read_value, got.first_empty, got.second_empty);
               end
            end else begin
               exp = pending_rsp.pop_front();
               if (got.status !== exp.status || got.read_value !== exp.read_value ||
                   got.first_empty !== exp.first_empty ||
                   got.second_empty !== exp.second_empty) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display({"response mismatch: expected status %0d read %h empty %b%b,",
                               " got status %0d read %h empty %b%b"},
                              exp.status, exp.read_value, exp.first_empty, exp.second_empty,
                              got.status, got.read_value, got.first_empty, got.second_empty);
                  end
               end
            end
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_type b;
      int      counted;
      int      phase_left;
      int      push_bias;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      steady     = 1'b0;
      mismatches = 0;
      depth_one  = 0;
      depth_two  = 0;
      foreach (store_image[i]) store_image[i] = '0;

      // Empty stacks refuse every read; spare codes change nothing
      add_row(OP_POP_ONE,  32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b1);
      add_row(OP_POP_TWO,  32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b1);
      add_row(OP_PEEK_ONE, 32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b1);
      add_row(OP_PEEK_TWO, 32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b1);
      add_row(OP_SPARE_LO, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b1, 1'b1);
      add_row(OP_SPARE_HI, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b1, 1'b1);
      // Extreme values through each stack
      add_row(OP_PUSH_ONE, 32'h7FFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b0, 1'b1);
      add_row(OP_PUSH_TWO, 32'h8000_0000, 1'b1, ST_OK, 32'h0, 1'b0, 1'b0);
      add_row(OP_PEEK_ONE, 32'h0, 1'b1, ST_OK, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_row(OP_PEEK_TWO, 32'h0, 1'b1, ST_OK, 32'h8000_0000, 1'b0, 1'b0);
      // Fill the store until the tops meet
      for (int i = 0; i < STORE_DEPTH - 2; i++) begin
         add_row((i < 9) ? OP_PUSH_ONE : OP_PUSH_TWO,
                 (i % 2 == 0) ? 32'hFFFF_FFFF ^ (32'h1 << i) : 32'h1 << (31 - i),
                 1'b0, ST_OK, 32'h0, 1'b0, 1'b0);
      end
      add_row(OP_PUSH_ONE, 32'h1234_5678, 1'b1, ST_FULL, 32'h0, 1'b0, 1'b0);
      add_row(OP_PUSH_TWO, 32'h0, 1'b1, ST_FULL, 32'h0, 1'b0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].want);

      // Random phases that lean toward pushes or toward reads
      counted    = 0;
      phase_left = 0;
      push_bias  = 50;
      while (counted < RANDOM_BEATS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(60, 10);
            case ($urandom_range(2))
               0: push_bias = 20;
               1: push_bias = 50;
               default: push_bias = 80;
            endcase
         end
         phase_left--;
         b.push_value = $urandom();
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: b.push_value = 32'h7FFF_FFFF;
               1: b.push_value = 32'h8000_0000;
               2: b.push_value = 32'h0;
               default: b.push_value = 32'hFFFF_FFFF;
            endcase
         end
         if ($urandom_range(99) < 5) begin
            b.operation = 3'($urandom_range(7));
         end else if ($urandom_range(99) < push_bias) begin
            b.operation = $urandom_range(1) ? OP_PUSH_TWO : OP_PUSH_ONE;
         end else begin
            case ($urandom_range(7))
               0, 1, 2: b.operation = OP_POP_ONE;
               3, 4, 5: b.operation = OP_POP_TWO;
               6:       b.operation = OP_PEEK_ONE;
               default: b.operation = OP_PEEK_TWO;
            endcase
         end
         if (b.operation <= OP_PEEK_TWO) counted++;
         steady = (counted >= STEADY_FIRST) && (counted < STEADY_LAST);
         send_beat(b, 1'b0, '0);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // Drain outstanding responses, then watch for stray beats
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
